// File: src/obbsat_pkg.sv
`timescale 1ns / 1ps
package obbsat_pkg;

	localparam int PW = 58;

	typedef logic signed [PW-1:0] prj_t;

	typedef enum logic [1:0] {
		AX_FA,
		AX_FB,
		AX_SA,
		AX_SB
	} axis_e;

	typedef struct packed {
		logic        gap;
		logic        dneg;
		prj_t        ov;
	} axis_res_t;

	typedef struct packed {
		logic [15:0]        id1;
		logic [15:0]        id2;
		logic signed [23:0] p1x;
		logic signed [23:0] p1y;
		logic signed [23:0] p2x;
		logic signed [23:0] p2y;
		logic [22:0]        w1;
		logic [22:0]        h1;
		logic [22:0]        w2;
		logic [22:0]        h2;
		logic               empty;
	} pay_t;

	typedef struct packed {
		logic [15:0]        id1;
		logic [15:0]        id2;
		logic signed [23:0] p1x;
		logic signed [23:0] p1y;
		logic               empty;
		logic signed [15:0] sn1;
		logic signed [15:0] cs1;
		logic signed [15:0] sn2;
		logic signed [15:0] cs2;
	} tail_t;

	function automatic prj_t minz(prj_t x);
		return x[PW-1] ? x : '0;
	endfunction

	function automatic prj_t maxz(prj_t x);
		return x[PW-1] ? '0 : x;
	endfunction

	function automatic logic signed [23:0] sat24(logic signed [25:0] v);
		if (v > 26'sd8388607)
			return 24'sh7FFFFF;
		else if (v < -26'sd8388608)
			return 24'sh800000;
		else
			return v[23:0];
	endfunction

endpackage

// File: src/obbsat_sine.sv
`timescale 1ns / 1ps
module obbsat_sine (
	input  logic               clk,
	input  logic               en,
	input  logic [15:0]        angle,
	output logic signed [15:0] val
);
	logic [14:0] t_in;
	logic [29:0] tt;
	logic [14:0] t_s1, t2_s1;
	logic        neg_s1;
	logic [24:0] ti;
	logic [14:0] t_s2;
	logic [14:0] t2_s2;
	logic [13:0] i_s2;
	logic        neg_s2;
	logic [28:0] tm;
	logic [14:0] t_s3, m_s3;
	logic        neg_s3;
	logic [29:0] ts;
	logic signed [15:0] val_s4;

	// reflect the second and fourth quadrants
	assign t_in = angle[14] ? (15'd16384 - {1'b0, angle[13:0]}) : {1'b0, angle[13:0]};
	assign tt   = 30'(t_in) * 30'(t_in);
	assign ti   = 25'(t2_s1) * 25'd1160;
	assign tm   = 29'(t2_s2) * 29'(i_s2);
	assign ts   = 30'(t_s3) * 30'(m_s3);

	always_ff @(posedge clk) begin
		if (en) begin
			t_s1   <= t_in;
			t2_s1  <= tt[28:14];
			neg_s1 <= angle[15];
			t_s2   <= t_s1;
			t2_s2  <= t2_s1;
			i_s2   <= 14'(14'd10512 - 14'(ti[24:14]));
			neg_s2 <= neg_s1;
			t_s3   <= t_s2;
			m_s3   <= 15'(15'd25736 - 15'(tm[27:14]));
			neg_s3 <= neg_s2;
			val_s4 <= neg_s3 ? -$signed(ts[29:14]) : $signed(ts[29:14]);
		end
	end

	assign val = val_s4;
endmodule

// File: src/obbsat_proj.sv
`timescale 1ns / 1ps
module obbsat_proj (
	input  logic               clk,
	input  logic               en,
	input  logic signed [39:0] wc1,
	input  logic signed [39:0] ws1,
	input  logic signed [39:0] hc1,
	input  logic signed [39:0] hs1,
	input  logic signed [39:0] wc2,
	input  logic signed [39:0] ws2,
	input  logic signed [39:0] hc2,
	input  logic signed [39:0] hs2,
	input  logic signed [24:0] dx,
	input  logic signed [24:0] dy,
	input  logic signed [15:0] nx,
	input  logic signed [15:0] ny,
	output obbsat_pkg::axis_res_t res
);
	import obbsat_pkg::*;

	logic signed [55:0] a1_s6, b1_s6, c1_s6, d1_s6, a2_s6, b2_s6, c2_s6, d2_s6;
	logic signed [41:0] dn_s6;
	prj_t ew1_s7, eh1_s7, ew2_s7, eh2_s7, d_s7;
	logic dneg_s7, dneg_s8;
	prj_t mn1_s8, mx1_s8, mn2_s8, mx2_s8;
	prj_t lo, hi;
	axis_res_t res_s9;

	always_ff @(posedge clk) begin
		if (en) begin
			a1_s6 <= wc1 * nx;
			b1_s6 <= ws1 * ny;
			c1_s6 <= hs1 * nx;
			d1_s6 <= hc1 * ny;
			a2_s6 <= wc2 * nx;
			b2_s6 <= ws2 * ny;
			c2_s6 <= hs2 * nx;
			d2_s6 <= hc2 * ny;
			dn_s6 <= dx * nx + dy * ny;

			// edge projections; box 1 sits at the origin
			ew1_s7  <= a1_s6 + b1_s6;
			eh1_s7  <= d1_s6 - c1_s6;
			ew2_s7  <= a2_s6 + b2_s6;
			eh2_s7  <= d2_s6 - c2_s6;
			d_s7    <= {dn_s6[41], dn_s6[41], dn_s6, 14'd0};
			dneg_s7 <= dn_s6[41];

			mn1_s8  <= minz(ew1_s7) + minz(eh1_s7);
			mx1_s8  <= maxz(ew1_s7) + maxz(eh1_s7);
			mn2_s8  <= d_s7 + minz(ew2_s7) + minz(eh2_s7);
			mx2_s8  <= d_s7 + maxz(ew2_s7) + maxz(eh2_s7);
			dneg_s8 <= dneg_s7;

			res_s9.gap  <= (mn1_s8 > mx2_s8) || (mn2_s8 > mx1_s8);
			res_s9.dneg <= dneg_s8;
			res_s9.ov   <= hi - lo;
		end
	end

	assign lo  = (mn1_s8 > mn2_s8) ? mn1_s8 : mn2_s8;
	assign hi  = (mx1_s8 < mx2_s8) ? mx1_s8 : mx2_s8;
	assign res = res_s9;
endmodule

// File: src/obb_sat_collision_test.sv
`timescale 1ns / 1ps
// Throughput: one box pair per cycle; the whole pipeline stalls together while
// the output holds an untaken result.
// Reset: arst_n clears the stage valid bits only; data registers are not reset.
// The four sine units (four multiply stages) and the 40x16 projection products
// set the depth.
module obb_sat_collision_test (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// first_id, second_id, first_pos_x, first_pos_y, first_width, first_height,
	// first_angle, second_pos_x, second_pos_y, second_width, second_height,
	// second_angle, zero pad
	input  logic [255:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// first_id, second_id, overlap_depth, normal_x, normal_y, contact_x,
	// contact_y, zero pad
	output logic [135:0] m_tdata,
	// hit
	output logic [0:0]   m_tuser
);
	import obbsat_pkg::*;

	logic en;
	logic [14:1] vld_q;
	pay_t pay_in;
	pay_t pay_s [1:4];
	logic signed [15:0] sn1, cs1, sn2, cs2;

	logic signed [39:0] wc1_s5, ws1_s5, hc1_s5, hs1_s5, wc2_s5, ws2_s5, hc2_s5, hs2_s5;
	logic signed [24:0] dx_s5, dy_s5;
	tail_t tail_s [5:11];
	axis_res_t res [4];

	prj_t ovab_s10, ovcd_s10, best_s11;
	axis_e axab_s10, axcd_s10, ax_s11;
	logic dnab_s10, dncd_s10, gap_s10, dn_s11, gap_s11;

	logic hit_s12, hit_s13, hit_s14;
	logic [22:0] dep_s12, dep_s13, dep_s14;
	logic signed [15:0] nx_s12, ny_s12, nx_s13, ny_s13, nx_s14, ny_s14;
	logic signed [15:0] nxs, nys;
	logic [15:0] id1_s12, id2_s12, id1_s13, id2_s13, id1_s14, id2_s14;
	logic signed [23:0] p1x_s12, p1y_s12, p1x_s13, p1y_s13, cx_s14, cy_s14;
	logic signed [39:0] prx_s13, pry_s13;
	logic signed [25:0] sumx, sumy;

	assign en       = !vld_q[14] || m_tready;
	assign s_tready = en;
	assign m_tvalid = vld_q[14];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[13:1], s_tvalid};
		end
	end

	assign pay_in.id1   = s_tdata[15:0];
	assign pay_in.id2   = s_tdata[31:16];
	assign pay_in.p1x   = s_tdata[55:32];
	assign pay_in.p1y   = s_tdata[79:56];
	assign pay_in.w1    = s_tdata[102:80];
	assign pay_in.h1    = s_tdata[125:103];
	assign pay_in.p2x   = s_tdata[165:142];
	assign pay_in.p2y   = s_tdata[189:166];
	assign pay_in.w2    = s_tdata[212:190];
	assign pay_in.h2    = s_tdata[235:213];
	assign pay_in.empty = (s_tdata[102:80] == '0) || (s_tdata[125:103] == '0) ||
	                      (s_tdata[212:190] == '0) || (s_tdata[235:213] == '0);

	obbsat_sine u_sin1 (.clk, .en, .angle(s_tdata[141:126]), .val(sn1));
	obbsat_sine u_cos1 (.clk, .en, .angle(16'(s_tdata[141:126] + 16'd16384)), .val(cs1));
	obbsat_sine u_sin2 (.clk, .en, .angle(s_tdata[251:236]), .val(sn2));
	obbsat_sine u_cos2 (.clk, .en, .angle(16'(s_tdata[251:236] + 16'd16384)), .val(cs2));

	always_ff @(posedge clk) begin
		if (en) begin
			pay_s[1] <= pay_in;
			for (int k = 2; k <= 4; k++) begin
				pay_s[k] <= pay_s[k-1];
			end

			wc1_s5 <= $signed({1'b0, pay_s[4].w1}) * cs1;
			ws1_s5 <= $signed({1'b0, pay_s[4].w1}) * sn1;
			hc1_s5 <= $signed({1'b0, pay_s[4].h1}) * cs1;
			hs1_s5 <= $signed({1'b0, pay_s[4].h1}) * sn1;
			wc2_s5 <= $signed({1'b0, pay_s[4].w2}) * cs2;
			ws2_s5 <= $signed({1'b0, pay_s[4].w2}) * sn2;
			hc2_s5 <= $signed({1'b0, pay_s[4].h2}) * cs2;
			hs2_s5 <= $signed({1'b0, pay_s[4].h2}) * sn2;
			dx_s5  <= 25'(pay_s[4].p2x) - 25'(pay_s[4].p1x);
			dy_s5  <= 25'(pay_s[4].p2y) - 25'(pay_s[4].p1y);

			tail_s[5].id1   <= pay_s[4].id1;
			tail_s[5].id2   <= pay_s[4].id2;
			tail_s[5].p1x   <= pay_s[4].p1x;
			tail_s[5].p1y   <= pay_s[4].p1y;
			tail_s[5].empty <= pay_s[4].empty;
			tail_s[5].sn1   <= sn1;
			tail_s[5].cs1   <= cs1;
			tail_s[5].sn2   <= sn2;
			tail_s[5].cs2   <= cs2;
			for (int k = 6; k <= 11; k++) begin
				tail_s[k] <= tail_s[k-1];
			end
		end
	end

	// distinct axes only: the other two of each box are negations with equal overlap
	obbsat_proj u_pa (.clk, .en, .wc1(wc1_s5), .ws1(ws1_s5), .hc1(hc1_s5), .hs1(hs1_s5),
		.wc2(wc2_s5), .ws2(ws2_s5), .hc2(hc2_s5), .hs2(hs2_s5), .dx(dx_s5), .dy(dy_s5),
		.nx(tail_s[5].sn1), .ny(-tail_s[5].cs1), .res(res[0]));
	obbsat_proj u_pb (.clk, .en, .wc1(wc1_s5), .ws1(ws1_s5), .hc1(hc1_s5), .hs1(hs1_s5),
		.wc2(wc2_s5), .ws2(ws2_s5), .hc2(hc2_s5), .hs2(hs2_s5), .dx(dx_s5), .dy(dy_s5),
		.nx(tail_s[5].cs1), .ny(tail_s[5].sn1), .res(res[1]));
	obbsat_proj u_pc (.clk, .en, .wc1(wc1_s5), .ws1(ws1_s5), .hc1(hc1_s5), .hs1(hs1_s5),
		.wc2(wc2_s5), .ws2(ws2_s5), .hc2(hc2_s5), .hs2(hs2_s5), .dx(dx_s5), .dy(dy_s5),
		.nx(tail_s[5].sn2), .ny(-tail_s[5].cs2), .res(res[2]));
	obbsat_proj u_pd (.clk, .en, .wc1(wc1_s5), .ws1(ws1_s5), .hc1(hc1_s5), .hs1(hs1_s5),
		.wc2(wc2_s5), .ws2(ws2_s5), .hc2(hc2_s5), .hs2(hs2_s5), .dx(dx_s5), .dy(dy_s5),
		.nx(tail_s[5].cs2), .ny(tail_s[5].sn2), .res(res[3]));

	always_comb begin
		case (ax_s11)
			AX_FA: begin
				nxs = tail_s[11].sn1;
				nys = -tail_s[11].cs1;
			end
			AX_FB: begin
				nxs = tail_s[11].cs1;
				nys = tail_s[11].sn1;
			end
			AX_SA: begin
				nxs = tail_s[11].sn2;
				nys = -tail_s[11].cs2;
			end
			default: begin
				nxs = tail_s[11].cs2;
				nys = tail_s[11].sn2;
			end
		endcase
	end

	assign sumx = {{2{p1x_s13[23]}}, p1x_s13} + {prx_s13[39], prx_s13[39:15]};
	assign sumy = {{2{p1y_s13[23]}}, p1y_s13} + {pry_s13[39], pry_s13[39:15]};

	always_ff @(posedge clk) begin
		if (en) begin
			// earlier axis wins ties
			if (res[1].ov < res[0].ov) begin
				ovab_s10 <= res[1].ov;
				axab_s10 <= AX_FB;
				dnab_s10 <= res[1].dneg;
			end else begin
				ovab_s10 <= res[0].ov;
				axab_s10 <= AX_FA;
				dnab_s10 <= res[0].dneg;
			end
			if (res[3].ov < res[2].ov) begin
				ovcd_s10 <= res[3].ov;
				axcd_s10 <= AX_SB;
				dncd_s10 <= res[3].dneg;
			end else begin
				ovcd_s10 <= res[2].ov;
				axcd_s10 <= AX_SA;
				dncd_s10 <= res[2].dneg;
			end
			gap_s10 <= res[0].gap || res[1].gap || res[2].gap || res[3].gap;

			if (ovcd_s10 < ovab_s10) begin
				best_s11 <= ovcd_s10;
				ax_s11   <= axcd_s10;
				dn_s11   <= dncd_s10;
			end else begin
				best_s11 <= ovab_s10;
				ax_s11   <= axab_s10;
				dn_s11   <= dnab_s10;
			end
			gap_s11 <= gap_s10;

			hit_s12 <= !tail_s[11].empty && !gap_s11;
			dep_s12 <= (|best_s11[PW-1:51]) ? 23'h7FFFFF : best_s11[50:28];
			nx_s12  <= dn_s11 ? -nxs : nxs;
			ny_s12  <= dn_s11 ? -nys : nys;
			id1_s12 <= tail_s[11].id1;
			id2_s12 <= tail_s[11].id2;
			p1x_s12 <= tail_s[11].p1x;
			p1y_s12 <= tail_s[11].p1y;

			prx_s13 <= nx_s12 * $signed({1'b0, dep_s12});
			pry_s13 <= ny_s12 * $signed({1'b0, dep_s12});
			hit_s13 <= hit_s12;
			dep_s13 <= dep_s12;
			nx_s13  <= nx_s12;
			ny_s13  <= ny_s12;
			id1_s13 <= id1_s12;
			id2_s13 <= id2_s12;
			p1x_s13 <= p1x_s12;
			p1y_s13 <= p1y_s12;

			hit_s14 <= hit_s13;
			id1_s14 <= id1_s13;
			id2_s14 <= id2_s13;
			dep_s14 <= hit_s13 ? dep_s13 : '0;
			nx_s14  <= hit_s13 ? nx_s13 : '0;
			ny_s14  <= hit_s13 ? ny_s13 : '0;
			cx_s14  <= hit_s13 ? sat24(sumx) : '0;
			cy_s14  <= hit_s13 ? sat24(sumy) : '0;
		end
	end

	assign m_tdata = {1'b0, cy_s14, cx_s14, ny_s14, nx_s14, dep_s14, id2_s14, id1_s14};
	assign m_tuser = hit_s14;
endmodule

// File: src/obbsat_chk.sv
`timescale 1ns / 1ps
module obbsat_chk (
	input logic         clk,
	input logic         arst_n,
	input logic         s_tvalid,
	input logic         s_tready,
	input logic [255:0] s_tdata,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [135:0] m_tdata,
	input logic [0:0]   m_tuser
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	a_nohit_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata[134:32] == '0)
		else $error("miss carries nonzero fields");

	a_normal: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata[86:55] != '0)
		else $error("hit with zero normal");

	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready == (!m_tvalid || m_tready))
		else $error("input ready out of step with output stall");
endmodule

bind obb_sat_collision_test obbsat_chk u_chk (.*);
